// ===== rtl/circular_deque_engine_defines.svh =====
// assertion macros for the circular deque engine
`ifndef CIRCULAR_DEQUE_ENGINE_DEFINES_SVH
`define CIRCULAR_DEQUE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define CDE_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("circular_deque_engine: invariant violated");
// consequent must hold in the cycle after the antecedent
`define CDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("circular_deque_engine: sequence violated");
`else
`define CDE_ASSERT_HOLDS(label, clk, rst, ante, cons)
`define CDE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/cde_pkg.sv =====
package cde_pkg;

   // request command codes
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_READ_INDEX = 3'd4;
   localparam logic [2:0] CMD_RESIZE     = 3'd5;
   localparam logic [2:0] CMD_CLEAR      = 3'd6;

   // response status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_RANGE     = 3'd3;
   localparam logic [2:0] ST_TOO_LARGE = 3'd4;

   // request payload
   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] data_value;
      logic [10:0] position;
   } cde_req_type;

   // response payload
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] read_value;
      logic [31:0] front_value;
      logic [31:0] back_value;
      logic [10:0] level;
      logic        empty_flag;
      logic        full_flag;
   } cde_rsp_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_WAIT = 4'b0100,
      S_FILL = 4'b1000
   } cde_state_type;

endpackage

// ===== rtl/cde_ram.sv =====
module cde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/circular_deque_engine.sv =====
// response path: push, clear, same-size resize and rejected requests pass S_EXEC, then the strobe register;
// pop, read and shrinking resize add S_WAIT for the registered store read;
// a growing resize adds S_FILL, which writes n - level entries (fill writes one entry per cycle)
// throughput: one request at a time, next accept possible in the strobe cycle
// reset: synchronous, clears pointers and level; store contents are not cleared
// results are strobed for one cycle; the receiver cannot stall
`include "circular_deque_engine_defines.svh"

module circular_deque_engine #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cde_pkg::cde_req_type req_payload,
   output logic                 rsp_strobe,
   output cde_pkg::cde_rsp_type rsp_payload
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;
   localparam int CMP_W = (CNT_W > 11) ? CNT_W : 11;
   localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

   // circular pointer helpers
   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_PTR : p - PTR_W'(1);
   endfunction

   // logical index to physical address, idx never above DEPTH
   function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                             input logic [CNT_W-1:0] idx);
      logic [CNT_W-1:0] s;
      s = {1'b0, head} + idx;
      return (s >= DEPTH_C) ? PTR_W'(s - DEPTH_C) : PTR_W'(s);
   endfunction

   cde_pkg::cde_state_type state_ff, state_in;
   cde_pkg::cde_req_type   req_ff, req_in;
   cde_pkg::cde_rsp_type   rsp_ff, rsp_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [CNT_W-1:0]       level_ff, level_in;
   logic [DATA_WIDTH-1:0]  front_ff, front_in;
   logic [DATA_WIDTH-1:0]  back_ff, back_in;
   logic [PTR_W-1:0]       fill_addr_ff, fill_addr_in;
   logic [CNT_W-1:0]       fill_left_ff, fill_left_in;

   logic                   ram_we;
   logic [PTR_W-1:0]       ram_waddr;
   logic [PTR_W-1:0]       ram_raddr;
   logic [DATA_WIDTH-1:0]  ram_rdata;
   logic [DATA_WIDTH-1:0]  val_c;
   logic [CMP_W-1:0]       pos_cmp_c;
   logic [CMP_W-1:0]       lvl_cmp_c;
   logic [CNT_W-1:0]       pos_cnt_c;
   logic [PTR_W-1:0]       new_tail_c;
   logic [PTR_W-1:0]       tail_expect_c;
   logic                   respond_c;
   logic [2:0]             rsp_status_c;
   logic [31:0]            rsp_read_c;

   // element store
   cde_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (val_c),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // operand views of the held request
   assign val_c      = DATA_WIDTH'(req_ff.data_value);
   assign pos_cmp_c  = CMP_W'(req_ff.position);
   assign lvl_cmp_c  = CMP_W'(level_ff);
   assign pos_cnt_c  = CNT_W'(req_ff.position);
   assign new_tail_c = wrap_dec(phys(head_ff, pos_cnt_c));

   // sequencer and pointer update
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      level_in      = level_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      fill_addr_in  = fill_addr_ff;
      fill_left_in  = fill_left_ff;
      ram_we        = 1'b0;
      ram_waddr     = fill_addr_ff;
      ram_raddr     = head_ff;
      respond_c     = 1'b0;
      rsp_status_c  = cde_pkg::ST_OK;
      rsp_read_c    = '0;
      unique case (state_ff)
         cde_pkg::S_IDLE: begin
            if (start) begin
               req_in   = req_payload;
               state_in = cde_pkg::S_EXEC;
            end
         end
         cde_pkg::S_EXEC: begin
            respond_c = 1'b1;
            unique case (req_ff.cmd)
               cde_pkg::CMD_PUSH_FRONT: begin
                  if (level_ff == DEPTH_C) begin
                     rsp_status_c = cde_pkg::ST_FULL;
                  end else begin
                     head_in   = wrap_dec(head_ff);
                     ram_we    = 1'b1;
                     ram_waddr = wrap_dec(head_ff);
                     level_in  = level_ff + CNT_W'(1);
                     front_in  = val_c;
                     if (level_ff == '0) begin
                        back_in = val_c;
                     end
                  end
               end
               cde_pkg::CMD_PUSH_BACK: begin
                  if (level_ff == DEPTH_C) begin
                     rsp_status_c = cde_pkg::ST_FULL;
                  end else begin
                     tail_in   = wrap_inc(tail_ff);
                     ram_we    = 1'b1;
                     ram_waddr = wrap_inc(tail_ff);
                     level_in  = level_ff + CNT_W'(1);
                     back_in   = val_c;
                     if (level_ff == '0) begin
                        front_in = val_c;
                     end
                  end
               end
               cde_pkg::CMD_POP_FRONT: begin
                  if (level_ff == '0) begin
                     rsp_status_c = cde_pkg::ST_EMPTY;
                  end else begin
                     head_in   = wrap_inc(head_ff);
                     level_in  = level_ff - CNT_W'(1);
                     ram_raddr = wrap_inc(head_ff);
                     respond_c = 1'b0;
                     state_in  = cde_pkg::S_WAIT;
                  end
               end
               cde_pkg::CMD_POP_BACK: begin
                  if (level_ff == '0) begin
                     rsp_status_c = cde_pkg::ST_EMPTY;
                  end else begin
                     tail_in   = wrap_dec(tail_ff);
                     level_in  = level_ff - CNT_W'(1);
                     ram_raddr = wrap_dec(tail_ff);
                     respond_c = 1'b0;
                     state_in  = cde_pkg::S_WAIT;
                  end
               end
               cde_pkg::CMD_READ_INDEX: begin
                  if (pos_cmp_c >= lvl_cmp_c) begin
                     rsp_status_c = cde_pkg::ST_RANGE;
                  end else begin
                     ram_raddr = phys(head_ff, pos_cnt_c);
                     respond_c = 1'b0;
                     state_in  = cde_pkg::S_WAIT;
                  end
               end
               cde_pkg::CMD_RESIZE: begin
                  if (pos_cmp_c > DEPTH_CMP) begin
                     rsp_status_c = cde_pkg::ST_TOO_LARGE;
                  end else begin
                     level_in = pos_cnt_c;
                     tail_in  = new_tail_c;
                     if (pos_cnt_c < level_ff) begin
                        // shrink: fetch the new back element
                        ram_raddr = new_tail_c;
                        respond_c = 1'b0;
                        state_in  = cde_pkg::S_WAIT;
                     end else if (pos_cnt_c > level_ff) begin
                        // grow: fill from the slot after the old tail onward
                        back_in = val_c;
                        if (level_ff == '0) begin
                           front_in = val_c;
                        end
                        fill_addr_in = wrap_inc(tail_ff);
                        fill_left_in = pos_cnt_c - level_ff;
                        respond_c    = 1'b0;
                        state_in     = cde_pkg::S_FILL;
                     end
                  end
               end
               cde_pkg::CMD_CLEAR: begin
                  head_in  = '0;
                  tail_in  = LAST_PTR;
                  level_in = '0;
               end
               default: begin
               end
            endcase
            if (respond_c) begin
               state_in = cde_pkg::S_IDLE;
            end
         end
         cde_pkg::S_WAIT: begin
            // store read data is valid now
            respond_c = 1'b1;
            state_in  = cde_pkg::S_IDLE;
            if (req_ff.cmd == cde_pkg::CMD_POP_FRONT) begin
               front_in = ram_rdata;
            end else if (req_ff.cmd == cde_pkg::CMD_READ_INDEX) begin
               rsp_read_c = 32'(ram_rdata);
            end else begin
               back_in = ram_rdata;
            end
         end
         cde_pkg::S_FILL: begin
            ram_we       = 1'b1;
            fill_addr_in = wrap_inc(fill_addr_ff);
            fill_left_in = fill_left_ff - CNT_W'(1);
            if (fill_left_ff == CNT_W'(1)) begin
               respond_c = 1'b1;
               state_in  = cde_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cde_pkg::S_IDLE;
         end
      endcase
   end

   // response formatting from the updated state
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      if (respond_c) begin
         rsp_strobe_in          = 1'b1;
         rsp_in.status          = rsp_status_c;
         rsp_in.read_value      = rsp_read_c;
         rsp_in.front_value     = (level_in == '0) ? '0 : 32'(front_in);
         rsp_in.back_value      = (level_in == '0) ? '0 : 32'(back_in);
         rsp_in.level           = 11'(level_in);
         rsp_in.empty_flag      = (level_in == '0);
         rsp_in.full_flag       = (level_in == DEPTH_C);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cde_pkg::S_IDLE;
         head_ff       <= '0;
         tail_ff       <= LAST_PTR;
         level_ff      <= '0;
         fill_left_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         level_ff      <= level_in;
         fill_left_ff  <= fill_left_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      front_ff     <= front_in;
      back_ff      <= back_in;
      fill_addr_ff <= fill_addr_in;
   end

   assign busy        = (state_ff != cde_pkg::S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // tail always sits one before head plus level
   assign tail_expect_c = wrap_dec(phys(head_ff, level_ff));

   `CDE_ASSERT_HOLDS(a_level_bound, clock, reset, 1'b1, level_ff <= DEPTH_C)
   `CDE_ASSERT_HOLDS(a_tail_track, clock, reset, 1'b1, tail_ff == tail_expect_c)
   `CDE_ASSERT_HOLDS(a_fill_nonzero, clock, reset, state_ff == cde_pkg::S_FILL, fill_left_ff != '0)
   `CDE_ASSERT_HOLDS(a_strobe_idle, clock, reset, rsp_strobe_ff, state_ff == cde_pkg::S_IDLE)

endmodule
